// ===== hw/rtl/wide_integer_alu_unit_defines.svh =====
// Assertion macros used by the wide ALU top level.
`ifndef WIDE_INTEGER_ALU_UNIT_DEFINES_SVH
`define WIDE_INTEGER_ALU_UNIT_DEFINES_SVH
`ifndef SYNTH
`define WIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WIA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/wia_pkg.sv =====
package wia_pkg;

    localparam int MAX_BYTES = 16;
    localparam int WIDE_BITS = 128;
    localparam int SHIFT_BITS = 8;
    localparam int WIDTH_BITS = 5;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0,
        ACT_SUB = 4'd1,
        ACT_CMP = 4'd2,
        ACT_NEG = 4'd3,
        ACT_NOT = 4'd4,
        ACT_AND = 4'd5,
        ACT_OR  = 4'd6,
        ACT_XOR = 4'd7,
        ACT_SHL = 4'd8,
        ACT_SHR = 4'd9,
        ACT_MUL = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    localparam logic [1:0] REG_WIDTH_ADDR = 2'd0;

    // Front stage to the multiply stage.
    typedef struct packed {
        logic                  valid;
        logic [3:0]            action;
        logic [WIDE_BITS-1:0]  mask;
        logic [WIDE_BITS-1:0]  a;
        logic [WIDE_BITS-1:0]  b;
        logic [SHIFT_BITS-1:0] shift;
        logic                  shift_ok;
        logic [1:0]            cmp;
    } front_t;

    // Multiply/logic stage to the final stage.
    // The x terms come from a_low * b_high and the y terms from a_high * b_low;
    // only their low 64 bits matter.
    typedef struct packed {
        logic                 valid;
        logic [WIDE_BITS-1:0] mask;
        logic [WIDE_BITS-1:0] result;
        logic                 is_mul;
        logic [63:0]          p00;
        logic [63:0]          p01;
        logic [63:0]          p10;
        logic [63:0]          p11;
        logic [63:0]          x00;
        logic [31:0]          x01;
        logic [31:0]          x10;
        logic [63:0]          y00;
        logic [31:0]          y01;
        logic [31:0]          y10;
        logic [1:0]           cmp;
    } mid_t;

endpackage

// ===== hw/rtl/wia_front.sv =====
module wia_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [3:0]                      action,
    input  logic [63:0]                     a_low,
    input  logic [63:0]                     a_high,
    input  logic [63:0]                     b_low,
    input  logic [63:0]                     b_high,
    input  logic [7:0]                      shift_amount,
    input  logic [wia_pkg::WIDTH_BITS-1:0]  width_bytes,
    output wia_pkg::front_t                 front
);
    import wia_pkg::*;

    front_t front_reg;
    front_t front_next;
    logic [4:0] eff_bytes;
    logic [7:0] bits;
    logic [WIDE_BITS-1:0] mask;
    logic [WIDE_BITS-1:0] a_m;
    logic [WIDE_BITS-1:0] b_m;

    always_comb
    begin
        if (width_bytes == 5'd0)
            eff_bytes = 5'd1;
        else if (width_bytes > 5'(MAX_BYTES))
            eff_bytes = 5'(MAX_BYTES);
        else
            eff_bytes = width_bytes;
        bits = {eff_bytes, 3'b000};
        if (eff_bytes == 5'd16)
            mask = '1;
        else
            mask = ~({WIDE_BITS{1'b1}} << bits);
        a_m = {a_high, a_low} & mask;
        b_m = {b_high, b_low} & mask;
        front_next.valid = start;
        front_next.action = action;
        front_next.mask = mask;
        front_next.a = a_m;
        front_next.b = b_m;
        front_next.shift = shift_amount;
        front_next.shift_ok = ({1'b0, shift_amount} < {1'b0, bits});
        if (a_m == b_m)
            front_next.cmp = CMP_EQUAL;
        else if (a_m > b_m)
            front_next.cmp = CMP_GREATER;
        else
            front_next.cmp = CMP_LESS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

// ===== hw/rtl/wia_exec.sv =====
module wia_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  wia_pkg::front_t front,
    output wia_pkg::mid_t   mid
);
    import wia_pkg::*;

    mid_t mid_reg;
    mid_t mid_next;
    logic [63:0] al, ah, bl, bh;

    always_comb
    begin
        al = front.a[63:0];
        ah = front.a[127:64];
        bl = front.b[63:0];
        bh = front.b[127:64];
        mid_next.valid = front.valid;
        mid_next.mask = front.mask;
        mid_next.cmp = front.cmp;
        mid_next.is_mul = (front.action == ACT_MUL);
        mid_next.p00 = {32'd0, al[31:0]} * {32'd0, bl[31:0]};
        mid_next.p01 = {32'd0, al[31:0]} * {32'd0, bl[63:32]};
        mid_next.p10 = {32'd0, al[63:32]} * {32'd0, bl[31:0]};
        mid_next.p11 = {32'd0, al[63:32]} * {32'd0, bl[63:32]};
        // Only the low 64 bits of the cross terms reach the upper half.
        mid_next.x00 = {32'd0, al[31:0]} * {32'd0, bh[31:0]};
        mid_next.x01 = al[31:0] * bh[63:32];
        mid_next.x10 = al[63:32] * bh[31:0];
        mid_next.y00 = {32'd0, ah[31:0]} * {32'd0, bl[31:0]};
        mid_next.y01 = ah[31:0] * bl[63:32];
        mid_next.y10 = ah[63:32] * bl[31:0];
        unique case (front.action)
            ACT_ADD: mid_next.result = front.a + front.b;
            ACT_SUB: mid_next.result = front.a - front.b;
            ACT_NEG: mid_next.result = '0 - front.a;
            ACT_NOT: mid_next.result = ~front.a;
            ACT_AND: mid_next.result = front.a & front.b;
            ACT_OR:  mid_next.result = front.a | front.b;
            ACT_XOR: mid_next.result = front.a ^ front.b;
            ACT_SHL: mid_next.result = front.shift_ok ? (front.a << front.shift) : '0;
            ACT_SHR: mid_next.result = front.shift_ok ? (front.a >> front.shift) : '0;
            default: mid_next.result = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
        end
        else
        begin
            mid_reg <= mid_next;
        end
    end

    assign mid = mid_reg;

endmodule

// ===== hw/rtl/wide_integer_alu_unit.sv =====
// Channel  | Signals                                   | Handshake
// cfg      | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
// command  | action a_* b_* shift_amount               | start while busy low
// result   | result_low result_high compare_outcome    | done strobe, one cycle
// A start passes the front, multiply and done registers in that order.
// One command is taken every cycle; busy is always low.
// The cross product multipliers set the stage depth of the middle stage.
// Reset clears all valid bits and sets the width register to 16 bytes.
// The receiver cannot stall, so the pipeline never holds.
`include "wide_integer_alu_unit_defines.svh"
module wide_integer_alu_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  action,
    input  logic [63:0] a_low,
    input  logic [63:0] a_high,
    input  logic [63:0] b_low,
    input  logic [63:0] b_high,
    input  logic [7:0]  shift_amount,
    output logic        done,
    output logic [63:0] result_low,
    output logic [63:0] result_high,
    output logic [1:0]  compare_outcome
);
    import wia_pkg::*;

    logic [WIDTH_BITS-1:0] width_reg;
    front_t front;
    mid_t mid;
    logic done_reg;
    logic [127:0] out_reg;
    logic [127:0] out_next;
    logic [1:0] cmp_reg;
    logic [63:0] mid_sum;
    logic [31:0] cross_mid;
    logic [63:0] cross_sum;
    logic [127:0] mul_res;

    assign pready = 1'b1;
    assign busy = 1'b0;
    assign prdata = (paddr == REG_WIDTH_ADDR) ? {27'd0, width_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= 5'(MAX_BYTES);
        else if (psel && penable && pwrite && paddr == REG_WIDTH_ADDR)
            width_reg <= pwdata[WIDTH_BITS-1:0];
    end

    wia_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .a_low(a_low), .a_high(a_high), .b_low(b_low), .b_high(b_high),
        .shift_amount(shift_amount), .width_bytes(width_reg), .front(front)
    );

    wia_exec u_exec (.clk(clk), .rst_n(rst_n), .front(front), .mid(mid));

    always_comb
    begin
        mid_sum = {32'd0, mid.p00[63:32]} + {32'd0, mid.p01[31:0]}
                + {32'd0, mid.p10[31:0]};
        cross_mid = mid.x01 + mid.x10 + mid.y01 + mid.y10;
        cross_sum = mid.x00 + mid.y00 + {cross_mid, 32'd0};
        mul_res[63:0] = {mid_sum[31:0], mid.p00[31:0]};
        mul_res[127:64] = mid.p11 + {32'd0, mid.p01[63:32]}
                        + {32'd0, mid.p10[63:32]} + {32'd0, mid_sum[63:32]} + cross_sum;
        out_next = (mid.is_mul ? mul_res : mid.result) & mid.mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= mid.valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        cmp_reg <= mid.cmp;
    end

    assign done = done_reg;
    assign result_low = out_reg[63:0];
    assign result_high = out_reg[127:64];
    assign compare_outcome = cmp_reg;

    `WIA_ASSERT_NEXT(a_start_done3, clk, rst_n, start ##1 1'b1 ##1 1'b1, done)
    `WIA_ASSERT_IMPL(a_cmp_code, clk, rst_n, done, compare_outcome != 2'd3)
    `WIA_ASSERT_NEXT(a_valid_chain, clk, rst_n, front.valid, mid.valid)

endmodule

// ===== bench/tb_wide_integer_alu_unit.sv =====
`timescale 1ns / 1ps
module tb_wide_integer_alu_unit;
    import wia_pkg::*;

    typedef struct packed {
        logic [3:0]  act;
        logic [63:0] al;
        logic [63:0] ah;
        logic [63:0] bl;
        logic [63:0] bh;
        logic [7:0]  sh;
    } word_t;

    typedef struct packed {
        logic [63:0] rl;
        logic [63:0] rh;
        logic [1:0]  cmp;
    } alu_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [3:0]  action;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
    logic [7:0]  shift_amount;
    logic        done;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [1:0]  compare_outcome;

    word_t    pending_words[$];
    alu_out_t expected_results[$];
    logic [4:0] width_reg;
    int       mismatches = 0;
    int       cycle_count = 0;
    int       results_seen = 0;
    int       words_sent = 0;
    bit       idle_ok;
    bit       feeding = 1'b0;
    // A word presented but not yet accepted is held until busy is low at an edge.
    logic     start_hold;

    localparam int CYCLE_LIMIT = 200000;

    wide_integer_alu_unit uut (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Width-masked 128-bit ALU prediction.
    function automatic alu_out_t compute_alu(word_t w, logic [4:0] wreg);
        int           nbytes;
        int           nbits;
        logic [127:0] mask;
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] r;
        alu_out_t     o;
        nbytes = (wreg == 0) ? 1 : ((wreg > MAX_BYTES) ? MAX_BYTES : wreg);
        nbits = nbytes * 8;
        mask = (nbits == 128) ? {128{1'b1}} : ((128'd1 << nbits) - 128'd1);
        a = {w.ah, w.al} & mask;
        b = {w.bh, w.bl} & mask;
        r = '0;
        case (w.act)
            ACT_ADD: r = a + b;
            ACT_SUB: r = a - b;
            ACT_NEG: r = 128'd0 - a;
            ACT_NOT: r = ~a;
            ACT_AND: r = a & b;
            ACT_OR:  r = a | b;
            ACT_XOR: r = a ^ b;
            ACT_SHL: if (w.sh < nbits) r = a << w.sh;
            ACT_SHR: if (w.sh < nbits) r = a >> w.sh;
            ACT_MUL: r = a * b;
            default: r = '0;
        endcase
        r = r & mask;
        o.rl = r[63:0];
        o.rh = r[127:64];
        o.cmp = (a < b) ? CMP_LESS : ((a == b) ? CMP_EQUAL : CMP_GREATER);
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1;
            3: v = 64'h8000_0000_0000_0000;
            4: v = v & {56'd0, 8'hFF};
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_word(logic [3:0] act, logic [127:0] a, logic [127:0] b,
                              logic [7:0] sh);
        word_t w;
        w.act = act;
        w.al = a[63:0];
        w.ah = a[127:64];
        w.bl = b[63:0];
        w.bh = b[127:64];
        w.sh = sh;
        pending_words.push_back(w);
    endtask

    task automatic write_width(logic [4:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= REG_WIDTH_ADDR;
        pwdata <= {27'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        width_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || expected_results.size() != 0 || feeding)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Driver: presents the oldest pending word, with random gaps while idle_ok is set.
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
            action <= '0;
            a_low <= '0;
            a_high <= '0;
            b_low <= '0;
            b_high <= '0;
            shift_amount <= '0;
        end else begin
            if (!start_hold) begin
                if (pending_words.size() != 0 && (idle_ok ? ($urandom_range(0, 99) >= 12) : 1'b1))
                begin
                    word_t w;
                    w = pending_words.pop_front();
                    action <= w.act;
                    a_low <= w.al;
                    a_high <= w.ah;
                    b_low <= w.bl;
                    b_high <= w.bh;
                    shift_amount <= w.sh;
                    start <= 1'b1;
                    feeding <= 1'b1;
                end else begin
                    start <= 1'b0;
                    feeding <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_hold <= 1'b0;
        end else begin
            if (start && !busy) begin
                word_t w;
                w.act = action;
                w.al = a_low;
                w.ah = a_high;
                w.bl = b_low;
                w.bh = b_high;
                w.sh = shift_amount;
                expected_results.push_back(compute_alu(w, width_reg));
                words_sent <= words_sent + 1;
                start_hold <= 1'b0;
            end else begin
                start_hold <= start;
            end
        end
    end

    // Monitor: compares each done strobe with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && done) begin
            alu_out_t exp_r;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("result with no word pending: %h %h %0d",
                             result_high, result_low, compare_outcome);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.rl !== result_low || exp_r.rh !== result_high ||
                    exp_r.cmp !== compare_outcome) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %h_%h cmp %0d, got %h_%h cmp %0d",
                                 exp_r.rh, exp_r.rl, exp_r.cmp,
                                 result_high, result_low, compare_outcome);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_wide_integer_alu_unit: errors");
            $finish;
        end
    end

    initial begin
        logic [4:0]   widths[8];
        logic [127:0] ones;
        int           ph;
        int           k;
        widths = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd9, 5'd15, 5'd4};
        ones = {128{1'b1}};
        idle_ok = 1'b1;
        width_reg = 5'd16;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words at reset width: every action, extremes, shifts, bad codes.
        for (k = 0; k < 16; k++)
            queue_word(k[3:0], ones, 128'd1, 8'd0);
        queue_word(ACT_SHL, ones, ones, 8'd127);
        queue_word(ACT_SHL, ones, ones, 8'd128);
        queue_word(ACT_SHR, ones, 128'd0, 8'd255);
        queue_word(ACT_SHR, ones, 128'd0, 8'd64);
        queue_word(ACT_CMP, 128'd5, 128'd5, 8'd0);
        queue_word(ACT_MUL, ones, ones, 8'd0);
        queue_word(ACT_SUB, 128'd0, 128'd1, 8'd0);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            write_width(widths[ph]);
            for (k = 0; k < 100; k++)
                queue_word(4'($urandom_range(0, 99) < 95 ? $urandom_range(0, 10)
                                                           : $urandom_range(11, 15)),
                           {rand64(), rand64()}, {rand64(), rand64()},
                           8'($urandom_range(0, 255)));
            // One phase runs without gaps.
            idle_ok = (ph != 3);
            drain();
        end

        $display("covered %0d words over widths 16,1,0,31,8,9,15,4 with all actions",
                 words_sent);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_wide_integer_alu_unit: clean");
        else
            $display("tb_wide_integer_alu_unit: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wia_pkg.sv
hw/rtl/wia_front.sv
hw/rtl/wia_exec.sv
hw/rtl/wide_integer_alu_unit.sv
bench/tb_wide_integer_alu_unit.sv
